[hdl/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
// Holds the op and status codes, the controller state encoding and the controller/datapath interface structs.
// Depends on nothing.
`default_nettype none

package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_WALK_FRONT = 3'd6,
    OP_WALK_BACK  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LOAD = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic need_read;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

[hdl/deq_ctrl.sv]
// Controller state machine for the double-ended queue.
// Sequences capture, execution, memory reads and result hand-off.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output deq_pkg::cmd_t      cmd,
  input  wire deq_pkg::sts_t sts
);

  deq_pkg::state_t state;
  deq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      deq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_read ? deq_pkg::S_LOAD : deq_pkg::S_SEND;
      end
      deq_pkg::S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = deq_pkg::S_SEND;
      end
      deq_pkg::S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_next = deq_pkg::S_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = deq_pkg::S_LOAD;
          end
        end
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/deq_dp.sv]
// Datapath for the double-ended queue: entry memory, head and count, result register.
// Driven by the command struct from deq_ctrl and reports back through the status struct.
// Depends on deq_pkg.
`default_nettype none

module deq_dp #(
  parameter int DEPTH = 16,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire deq_pkg::cmd_t      cmd,
  output deq_pkg::sts_t           sts,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] value,
  input  wire logic [63:0]        name_low,
  input  wire logic [31:0]        name_high,
  output logic [1:0]              status,
  output logic signed [31:0]      entry_value,
  output logic [63:0]             entry_name_low,
  output logic [31:0]             entry_name_high,
  output logic                    last,
  output logic [CNT_W-1:0]        occupancy
);

  localparam int ENTRY_W = 128;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [2:0]   op_q;
  logic [31:0]  value_q;
  logic [63:0]  name_low_q;
  logic [31:0]  name_high_q;

  logic [PTR_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] idx;

  logic             is_push;
  logic             is_walk;
  logic             from_back;
  logic             full;
  logic             empty;
  logic [PTR_W-1:0] step_idx;
  logic [PTR_W-1:0] last_off;
  logic [PTR_W-1:0] rd_off;
  logic [PTR_W-1:0] rd_slot;
  logic [PTR_W-1:0] push_front_slot;
  logic [PTR_W-1:0] push_back_slot;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] wr_slot;
  logic             wr_en;
  logic             rd_en;

  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  always_comb begin
    is_push   = (op_q == deq_pkg::OP_PUSH_FRONT) || (op_q == deq_pkg::OP_PUSH_BACK);
    is_walk   = (op_q == deq_pkg::OP_WALK_FRONT) || (op_q == deq_pkg::OP_WALK_BACK);
    from_back = (op_q == deq_pkg::OP_POP_BACK) || (op_q == deq_pkg::OP_PEEK_BACK) ||
                (op_q == deq_pkg::OP_WALK_BACK);
    full      = (count == CNT_W'(DEPTH));
    empty     = (count == '0);
    sts.need_read = !is_push && !empty;
    sts.last      = last;
    step_idx  = cmd.exec ? '0 : idx + PTR_W'(1);
    last_off  = PTR_W'(count - CNT_W'(1));
    rd_off    = from_back ? last_off - step_idx : step_idx;
    rd_slot   = wrap(head, rd_off);
    push_front_slot = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
    push_back_slot  = wrap(head, PTR_W'(count));
    head_inc  = wrap(head, PTR_W'(1));
    wr_slot   = (op_q == deq_pkg::OP_PUSH_FRONT) ? push_front_slot : push_back_slot;
    wr_en     = cmd.exec && is_push && !full;
    rd_en     = (cmd.exec && sts.need_read) || cmd.step;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= {name_high_q, name_low_q, value_q};
    end
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q        <= op;
      value_q     <= value;
      name_low_q  <= name_low;
      name_high_q <= name_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (!full) begin
          count <= count + CNT_W'(1);
          if (op_q == deq_pkg::OP_PUSH_FRONT) begin
            head <= push_front_slot;
          end
        end
      end else if (!empty) begin
        if (op_q == deq_pkg::OP_POP_FRONT) begin
          head  <= head_inc;
          count <= count - CNT_W'(1);
        end else if (op_q == deq_pkg::OP_POP_BACK) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !sts.need_read) begin
      if (is_push) begin
        status    <= full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
        occupancy <= full ? count : count + CNT_W'(1);
      end else begin
        status    <= deq_pkg::ST_EMPTY;
        occupancy <= count;
      end
      entry_value     <= '0;
      entry_name_low  <= '0;
      entry_name_high <= '0;
      last            <= 1'b1;
    end else if (cmd.load) begin
      status          <= deq_pkg::ST_OK;
      entry_value     <= $signed(rd_data[31:0]);
      entry_name_low  <= rd_data[95:32];
      entry_name_high <= rd_data[127:96];
      last            <= !is_walk || (idx == last_off);
      occupancy       <= count;
    end
  end

endmodule

`default_nettype wire

[hdl/double_ended_queue.sv]
// Double-ended queue top level: joins the controller and the datapath.
// Depends on deq_pkg, deq_ctrl and deq_dp.
//
// A bounded queue of DEPTH entries, each a signed 32-bit value with a 12-byte name, held in
// a ring buffer with a head pointer and a count. One item is handled at a time: it is taken
// when in_ready is high, and the next item is taken in the cycle after its last result is
// accepted. A push, or any operation on an empty queue, goes through S_EXEC, where its
// result is registered, to S_SEND, which presents it; a pop or peek adds S_LOAD between
// them, which loads the registered read of the entry memory into the result. A walk gives
// one result per stored entry, each read from the entry memory and loaded in S_LOAD before
// S_SEND presents it; last marks the final result of every item.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] value,
  input  wire logic [63:0]        name_low,
  input  wire logic [31:0]        name_high,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic signed [31:0]      entry_value,
  output logic [63:0]             entry_name_low,
  output logic [31:0]             entry_name_high,
  output logic                    last,
  output logic [CNT_W-1:0]        occupancy
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .op              (op),
    .value           (value),
    .name_low        (name_low),
    .name_high       (name_high),
    .status          (status),
    .entry_value     (entry_value),
    .entry_name_low  (entry_name_low),
    .entry_name_high (entry_name_high),
    .last            (last),
    .occupancy       (occupancy)
  );

endmodule

`default_nettype wire
